// File: design/ordered_list_edit_engine_assert.svh
// Assertion macros for the ordered list edit engine.
// Used by the top level; expects signals clk and rst in the including scope.
`ifndef ORDERED_LIST_EDIT_ENGINE_ASSERT_SVH
`define ORDERED_LIST_EDIT_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property outside reset.
`define OLEE_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("olee assertion failed");
// Check a property at every edge, reset included.
`define OLEE_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("olee assertion failed");
`else
`define OLEE_ASSERT(name, prop)
`define OLEE_ASSERT_ALWAYS(name, prop)
`endif
`endif

// File: design/olee_pkg.sv
// Shared types and codes for the ordered list edit engine.
// No dependencies; used by olee_decode and ordered_list_edit_engine.
`timescale 1ns / 1ps
package olee_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int POS_W     = 5;
  localparam int DATA_W    = 32;

  // action codes
  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_BACK  = 3'd1;
  localparam logic [2:0] ACT_DEL_FRONT = 3'd2;
  localparam logic [2:0] ACT_DEL_BACK  = 3'd3;
  localparam logic [2:0] ACT_INS_AT    = 3'd4;
  localparam logic [2:0] ACT_DEL_AT    = 3'd5;
  localparam logic [2:0] ACT_LIST      = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  // plan kinds from the decoder
  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_INS  = 2'd1;
  localparam logic [1:0] K_DEL  = 2'd2;
  localparam logic [1:0] K_LIST = 2'd3;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]        position;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DATA_W-1:0] entry;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
  } plan_t;

endpackage

// File: design/olee_decode.sv
// Command decoder: checks an action against the current fill count.
// Depends on olee_pkg; instantiated by ordered_list_edit_engine.
`timescale 1ns / 1ps
module olee_decode #(
  parameter int DEPTH = olee_pkg::DEPTH_DEF
) (
  input  olee_pkg::cmd_t                 cmd,
  input  logic [$clog2(DEPTH+1)-1:0]     count,
  output olee_pkg::plan_t                plan,
  output logic [$clog2(DEPTH)-1:0]       idx
);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > olee_pkg::POS_W) ? CNT_W : olee_pkg::POS_W;

  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] pos1;
  logic [CMP_W-1:0] cnt_x;
  logic [CNT_W-1:0] cnt_m1;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign pos_x  = CMP_W'(cmd.position);
  assign cnt_x  = CMP_W'(count);
  assign pos1   = (pos_x == '0) ? CMP_W'(1) : pos_x;
  assign cnt_m1 = count - CNT_W'(1);

  always_comb begin
    plan.kind   = olee_pkg::K_NONE;
    plan.status = olee_pkg::ST_OK;
    idx         = '0;
    case (cmd.action)
      olee_pkg::ACT_INS_FRONT: begin
        if (full) plan.status = olee_pkg::ST_FULL;
        else      plan.kind   = olee_pkg::K_INS;
      end
      olee_pkg::ACT_INS_BACK: begin
        if (full) begin
          plan.status = olee_pkg::ST_FULL;
        end else begin
          plan.kind = olee_pkg::K_INS;
          idx       = count[IDX_W-1:0];
        end
      end
      olee_pkg::ACT_DEL_FRONT: begin
        if (empty) plan.status = olee_pkg::ST_EMPTY;
        else       plan.kind   = olee_pkg::K_DEL;
      end
      olee_pkg::ACT_DEL_BACK: begin
        if (empty) begin
          plan.status = olee_pkg::ST_EMPTY;
        end else begin
          plan.kind = olee_pkg::K_DEL;
          idx       = cnt_m1[IDX_W-1:0];
        end
      end
      olee_pkg::ACT_INS_AT: begin
        // empty first, then full, then the position range
        if (empty) begin
          plan.status = olee_pkg::ST_EMPTY;
        end else if (full) begin
          plan.status = olee_pkg::ST_FULL;
        end else if (pos1 > cnt_x) begin
          plan.status = olee_pkg::ST_BADPOS;
        end else begin
          plan.kind = olee_pkg::K_INS;
          idx       = pos1[IDX_W-1:0];
        end
      end
      olee_pkg::ACT_DEL_AT: begin
        if (empty) begin
          plan.status = olee_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          plan.status = olee_pkg::ST_BADPOS;
        end else begin
          plan.kind = olee_pkg::K_DEL;
          idx       = pos_x[IDX_W-1:0];
        end
      end
      olee_pkg::ACT_LIST: begin
        if (empty) plan.status = olee_pkg::ST_EMPTY;
        else       plan.kind   = olee_pkg::K_LIST;
      end
      default: begin
        plan.kind   = olee_pkg::K_NONE;
        plan.status = olee_pkg::ST_OK;
      end
    endcase
  end

endmodule

// File: design/ordered_list_edit_engine.sv
// Ordered list edit engine: up to DEPTH signed values; each cell move takes a read state and a write state.
// Refused or empty commands give one beat; an insert or delete moving m cells (m <= count)
//   gives its beat once the last move is done.
// A list of n entries streams n beats, one per cycle.
// Busy holds while the cell memory is being shifted or read; no new command is accepted while busy.
// Reset (rst, synchronous, active high) empties the list; cell contents are not cleared.
`timescale 1ns / 1ps
`include "ordered_list_edit_engine_assert.svh"
module ordered_list_edit_engine #(
  parameter int DEPTH = olee_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  olee_pkg::cmd_t cmd,
  output logic           strobe,
  output olee_pkg::rsp_t result
);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;  // read cell below cur, or drop value in
  localparam logic [2:0] S_IWR   = 3'd2;  // write moved cell up
  localparam logic [2:0] S_DEL   = 3'd3;  // read cell above cur, or finish
  localparam logic [2:0] S_DWR   = 3'd4;  // write moved cell down
  localparam logic [2:0] S_LIST  = 3'd5;  // issue one read per cycle
  localparam logic [2:0] S_DRAIN = 3'd6;  // last read data in flight

  logic [2:0]                   state;
  logic [CNT_W-1:0]             count;
  logic [IDX_W-1:0]             cur;
  logic [IDX_W-1:0]             tgt;
  logic signed [olee_pkg::DATA_W-1:0] val;
  logic                         pend;
  logic                         pend_last;

  // cell memory: one write and one registered read port
  logic signed [olee_pkg::DATA_W-1:0] cells [DEPTH];
  logic signed [olee_pkg::DATA_W-1:0] rd_data;
  logic signed [olee_pkg::DATA_W-1:0] wd;
  logic [IDX_W-1:0]             wa;
  logic [IDX_W-1:0]             ra;
  logic                         we;

  olee_pkg::plan_t              plan;
  logic [IDX_W-1:0]             plan_idx;
  logic                         accept;
  logic                         cur_at_end;
  logic                         ins_done;
  logic                         del_done;
  logic                         refuse;

  olee_decode #(
    .DEPTH (DEPTH)
  ) u_decode (
    .cmd   (cmd),
    .count (count),
    .plan  (plan),
    .idx   (plan_idx)
  );

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  // true when cur is the last occupied index
  assign cur_at_end = ((CNT_W'(cur) + CNT_W'(1)) == count);
  // an edit finishes when the value lands or the tail cell has been pulled down
  assign ins_done   = (state == S_INS) && (cur == tgt);
  assign del_done   = (state == S_DEL) && cur_at_end;
  // refusals, empty lists and unknown codes answer at once
  assign refuse     = accept && (plan.kind == olee_pkg::K_NONE);

  // memory port steering for the shared shift step
  always_comb begin
    we = 1'b0;
    wa = cur;
    wd = rd_data;
    ra = cur;
    case (state)
      S_INS: begin
        if (cur == tgt) begin
          we = 1'b1;
          wd = val;
        end else begin
          ra = cur - IDX_W'(1);
        end
      end
      S_IWR:   we = 1'b1;
      S_DEL: begin
        // no read past the tail
        if (!cur_at_end) ra = cur + IDX_W'(1);
      end
      S_DWR:   we = 1'b1;
      default: ra = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cells[wa] <= wd;
    end
    rd_data <= cells[ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      strobe <= 1'b0;
      pend   <= 1'b0;
    end else begin
      // a listed entry passes through rd_data and then the result register, with pend then strobe beside it
      strobe <= pend || refuse || ins_done || del_done;
      pend   <= (state == S_LIST);
      if (ins_done) begin
        count <= count + CNT_W'(1);
      end else if (del_done) begin
        count <= count - CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            tgt <= plan_idx;
            val <= cmd.value;
            case (plan.kind)
              olee_pkg::K_INS: begin
                // start shifting from the back end down to the target
                cur   <= count[IDX_W-1:0];
                state <= S_INS;
              end
              olee_pkg::K_DEL: begin
                cur   <= plan_idx;
                state <= S_DEL;
              end
              olee_pkg::K_LIST: begin
                cur   <= '0;
                state <= S_LIST;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_INS: state <= (cur == tgt) ? S_IDLE : S_IWR;
        S_IWR: begin
          cur   <= cur - IDX_W'(1);
          state <= S_INS;
        end
        S_DEL: state <= cur_at_end ? S_IDLE : S_DWR;
        S_DWR: begin
          cur   <= cur + IDX_W'(1);
          state <= S_DEL;
        end
        S_LIST: begin
          if (cur_at_end) state <= S_DRAIN;
          else            cur   <= cur + IDX_W'(1);
        end
        S_DRAIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register: hold the beat contents for the strobe cycle
  always_ff @(posedge clk) begin
    if (pend) begin
      result <= '{status: olee_pkg::ST_OK, entry: rd_data, last: pend_last};
    end else if (refuse) begin
      result <= '{status: plan.status, entry: '0, last: 1'b1};
    end else if (ins_done || del_done) begin
      result <= '{status: olee_pkg::ST_OK, entry: '0, last: 1'b1};
    end
    if (state == S_LIST) begin
      pend_last <= cur_at_end;
    end
  end

  // fill count never passes the depth
  `OLEE_ASSERT(a_count_range, count <= CNT_W'(DEPTH))
  // reset empties the list and drops any pending beat
  `OLEE_ASSERT_ALWAYS(a_reset_clears, rst |=> (count == '0) && !busy && !strobe)
  // a refusal is always a single, final beat
  `OLEE_ASSERT(a_err_single, strobe && (result.status != olee_pkg::ST_OK) |-> result.last)
  // one edit moves the count by at most one
  `OLEE_ASSERT(a_count_step, !$past(rst) |-> (count - $past(count) + CNT_W'(1)) <= CNT_W'(2))
  // a non-empty list holds busy and gives no beat on the next cycle
  `OLEE_ASSERT(a_list_busy, accept && (cmd.action == olee_pkg::ACT_LIST) && (count != '0) |=> busy && !strobe)

endmodule
